// ===== rtl/mep_pkg.sv =====
`timescale 1ns / 1ps

package mep_pkg;

  localparam int COORD_W   = 32;
  localparam int STEP_W    = 31;
  localparam int PIX_W     = 12;
  localparam int CNT_W     = 16;
  localparam int WIDE_W    = 45;
  localparam int PROD_W    = PIX_W + STEP_W;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int Q_FRAC    = 28;
  localparam int ESC_BIT   = 58;
  localparam int CFG_IDX_W = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd4;

  localparam logic [COORD_W-1:0] X_ORIGIN_RST = 32'hD800_0000;
  localparam logic [COORD_W-1:0] Y_ORIGIN_RST = 32'hE000_0000;
  localparam logic [STEP_W-1:0]  STEP_RST     = 31'd262144;
  localparam logic [CNT_W-1:0]   MAX_ITER_RST = 16'd200;

  localparam logic [23:0] INSIDE_RGB = {8'd16, 8'd16, 8'd16};

  typedef struct packed {
    logic [COORD_W-1:0] x_origin;
    logic [COORD_W-1:0] y_origin;
    logic [STEP_W-1:0]  x_step;
    logic [STEP_W-1:0]  y_step;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } coord_t;

  // clamp a two's complement value to the signed 32-bit range
  function automatic logic [COORD_W-1:0] sat32(input logic [WIDE_W-1:0] v);
    logic [COORD_W-1:0] res;
    if ((&v[WIDE_W-1:COORD_W-1]) || !(|v[WIDE_W-1:COORD_W-1])) begin
      res = v[COORD_W-1:0];
    end else if (v[WIDE_W-1]) begin
      res = 32'h8000_0000;
    end else begin
      res = 32'h7FFF_FFFF;
    end
    return res;
  endfunction

  // {red, green, blue}
  function automatic logic [23:0] gradient(input logic [3:0] idx);
    logic [23:0] rgb;
    unique case (idx)
      4'd0:  rgb = {8'd66,  8'd30,  8'd15};
      4'd1:  rgb = {8'd25,  8'd7,   8'd26};
      4'd2:  rgb = {8'd9,   8'd1,   8'd47};
      4'd3:  rgb = {8'd4,   8'd4,   8'd73};
      4'd4:  rgb = {8'd0,   8'd7,   8'd100};
      4'd5:  rgb = {8'd12,  8'd44,  8'd138};
      4'd6:  rgb = {8'd24,  8'd82,  8'd177};
      4'd7:  rgb = {8'd57,  8'd125, 8'd209};
      4'd8:  rgb = {8'd134, 8'd181, 8'd229};
      4'd9:  rgb = {8'd211, 8'd236, 8'd248};
      4'd10: rgb = {8'd241, 8'd233, 8'd191};
      4'd11: rgb = {8'd248, 8'd201, 8'd95};
      4'd12: rgb = {8'd255, 8'd170, 8'd0};
      4'd13: rgb = {8'd204, 8'd128, 8'd0};
      4'd14: rgb = {8'd153, 8'd87,  8'd0};
      4'd15: rgb = {8'd106, 8'd52,  8'd3};
    endcase
    return rgb;
  endfunction

endpackage

// ===== rtl/mep_front.sv =====
`timescale 1ns / 1ps

module mep_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mep_pkg::cfg_t                 cfg,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [2*mep_pkg::PIX_W-1:0]   in_tdata,
  input  logic                          q_full,
  output logic                          q_push,
  output mep_pkg::coord_t               q_wdata
);

  logic                           v1_r;
  logic                           v2_r;
  logic [mep_pkg::PROD_W-1:0]     prod_x_r;
  logic [mep_pkg::PROD_W-1:0]     prod_y_r;
  logic [mep_pkg::COORD_W-1:0]    cx_r;
  logic [mep_pkg::COORD_W-1:0]    cy_r;
  logic                           adv2;
  logic [mep_pkg::WIDE_W-1:0]     cx_wide;
  logic [mep_pkg::WIDE_W-1:0]     cy_wide;
  logic [mep_pkg::COORD_W:0]      cy_ext;
  logic [mep_pkg::COORD_W:0]      acy;
  logic [mep_pkg::COORD_W+1:0]    acy_x2;
  logic                           snap;

  assign adv2      = !v2_r || !q_full;
  assign in_tready = !v1_r || adv2;
  assign q_push    = v2_r && !q_full;

  assign cx_wide = {{(mep_pkg::WIDE_W-mep_pkg::COORD_W){cfg.x_origin[mep_pkg::COORD_W-1]}},
                    cfg.x_origin}
                 + {{(mep_pkg::WIDE_W-mep_pkg::PROD_W){1'b0}}, prod_x_r};
  assign cy_wide = {{(mep_pkg::WIDE_W-mep_pkg::COORD_W){cfg.y_origin[mep_pkg::COORD_W-1]}},
                    cfg.y_origin}
                 + {{(mep_pkg::WIDE_W-mep_pkg::PROD_W){1'b0}}, prod_y_r};

  // imaginary part snaps to zero within half a step of the axis
  assign cy_ext = {cy_r[mep_pkg::COORD_W-1], cy_r};
  assign acy    = cy_r[mep_pkg::COORD_W-1] ? (~cy_ext + 1'b1) : cy_ext;
  assign acy_x2 = {acy, 1'b0};
  assign snap   = acy_x2 < {3'b000, cfg.y_step};

  assign q_wdata.cx = cx_r;
  assign q_wdata.cy = snap ? '0 : cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (in_tready) v1_r <= in_tvalid;
      if (adv2)      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      prod_x_r <= mep_pkg::PROD_W'(in_tdata[mep_pkg::PIX_W-1:0])
                * mep_pkg::PROD_W'(cfg.x_step);
      prod_y_r <= mep_pkg::PROD_W'(in_tdata[2*mep_pkg::PIX_W-1:mep_pkg::PIX_W])
                * mep_pkg::PROD_W'(cfg.y_step);
    end
    if (adv2) begin
      cx_r <= mep_pkg::sat32(cx_wide);
      cy_r <= mep_pkg::sat32(cy_wide);
    end
  end

endmodule

// ===== rtl/mep_fifo.sv =====
`timescale 1ns / 1ps

module mep_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mep_pkg::coord_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            rvalid,
  output mep_pkg::coord_t rdata
);

  mep_pkg::coord_t                 entry_r [mep_pkg::QUEUE_DEPTH];
  logic [mep_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [mep_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [mep_pkg::QCNT_W-1:0]      fill_r;
  logic [mep_pkg::QCNT_W-1:0]      fill_nxt;

  assign full   = fill_r == mep_pkg::QCNT_W'(mep_pkg::QUEUE_DEPTH);
  assign rvalid = fill_r != '0;
  assign rdata  = entry_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) fill_nxt = fill_r + 1'b1;
    else if (!push && pop) fill_nxt = fill_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= wdata;
  end

endmodule

// ===== rtl/mep_iter.sv =====
`timescale 1ns / 1ps

module mep_iter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [mep_pkg::CNT_W-1:0]   max_iter,
  input  logic                        q_valid,
  input  mep_pkg::coord_t             q_rdata,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [47:0]                 out_tdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;

  logic [1:0]                         state_r;
  logic [1:0]                         state_nxt;
  logic [mep_pkg::CNT_W-1:0]          cnt_r;
  logic [mep_pkg::CNT_W-1:0]          cnt_nxt;
  logic [mep_pkg::COORD_W-1:0]        cx_r;
  logic [mep_pkg::COORD_W-1:0]        cy_r;
  logic signed [mep_pkg::COORD_W-1:0] zx_r;
  logic signed [mep_pkg::COORD_W-1:0] zy_r;
  logic signed [mep_pkg::SQ_W-1:0]    sx_r;
  logic signed [mep_pkg::SQ_W-1:0]    sy_r;
  logic signed [mep_pkg::SQ_W-1:0]    pxy_r;
  logic                               out_valid_r;
  logic [47:0]                        out_data_r;
  logic                               out_free;
  logic                               stop;
  logic                               emit;
  logic                               step;
  logic                               at_limit;
  logic [mep_pkg::SQ_W-1:0]           sq_sum;
  logic [mep_pkg::SQ_W-1:0]           sq_diff;
  logic [mep_pkg::WIDE_W-1:0]         nx_wide;
  logic [mep_pkg::WIDE_W-1:0]         ny_wide;
  logic [23:0]                        rgb;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  // squares come from the previous step; sum cannot wrap since each is at most 2^62
  assign sq_sum  = sx_r + sy_r;
  assign sq_diff = sx_r - sy_r;
  assign stop    = (cnt_r >= max_iter) || (|sq_sum[mep_pkg::SQ_W-1:mep_pkg::ESC_BIT]);

  // floor shifts: 2*zx*zy >> 28 is zx*zy >> 27
  assign ny_wide = {{(mep_pkg::WIDE_W-mep_pkg::SQ_W+mep_pkg::Q_FRAC-1){pxy_r[mep_pkg::SQ_W-1]}},
                    pxy_r[mep_pkg::SQ_W-1:mep_pkg::Q_FRAC-1]}
                 + {{(mep_pkg::WIDE_W-mep_pkg::COORD_W){cy_r[mep_pkg::COORD_W-1]}}, cy_r};
  assign nx_wide = {{(mep_pkg::WIDE_W-mep_pkg::SQ_W+mep_pkg::Q_FRAC){sq_diff[mep_pkg::SQ_W-1]}},
                    sq_diff[mep_pkg::SQ_W-1:mep_pkg::Q_FRAC]}
                 + {{(mep_pkg::WIDE_W-mep_pkg::COORD_W){cx_r[mep_pkg::COORD_W-1]}}, cx_r};

  assign at_limit = cnt_r == max_iter;
  assign rgb      = at_limit ? mep_pkg::INSIDE_RGB : mep_pkg::gradient(cnt_r[3:0]);

  assign q_pop = (state_r == ST_IDLE) && q_valid;
  assign emit  = (state_r == ST_ADD) && stop && out_free;
  assign step  = (state_r == ST_ADD) && !stop;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_ADD;
          cnt_nxt   = '0;
        end
      end
      ST_ADD: begin
        if (emit) begin
          state_nxt = ST_IDLE;
        end else if (step) begin
          state_nxt = ST_MUL;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      ST_MUL: state_nxt = ST_ADD;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cx_r  <= q_rdata.cx;
      cy_r  <= q_rdata.cy;
      zx_r  <= '0;
      zy_r  <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      pxy_r <= '0;
    end else if (step) begin
      zx_r <= mep_pkg::sat32(nx_wide);
      zy_r <= mep_pkg::sat32(ny_wide);
    end else if (state_r == ST_MUL) begin
      sx_r  <= zx_r * zx_r;
      sy_r  <= zy_r * zy_r;
      pxy_r <= zx_r * zy_r;
    end
    if (emit) begin
      out_data_r <= {7'd0, rgb[7:0], rgb[15:8], rgb[23:16], at_limit, cnt_r};
    end
  end

endmodule

// ===== rtl/mandelbrot_escape_pixel_core.sv =====
`timescale 1ns / 1ps
// pipeline: the coordinate front end registers the products and then the saturated c, the queue
// buffers c, and the iteration engine runs an update state and a multiply state per iteration
// flow: the iteration engine works on one pixel at a time and pops a new one only after
// the result of the last one has been emitted into the output register
// reset: synchronous active low; clears all pipeline and queue state and restores the
// configuration registers to their power-on values
module mandelbrot_escape_pixel_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,   // pixel_column, pixel_row
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [47:0]                     out_tdata,  // iteration_count, inside_set, red, green, blue
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mep_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);

  mep_pkg::cfg_t               cfg_r;
  logic [mep_pkg::CNT_W-1:0]   max_iter_r;
  logic                        q_full;
  logic                        q_push;
  mep_pkg::coord_t             q_wdata;
  logic                        q_valid;
  logic                        q_pop;
  mep_pkg::coord_t             q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_origin <= mep_pkg::X_ORIGIN_RST;
      cfg_r.y_origin <= mep_pkg::Y_ORIGIN_RST;
      cfg_r.x_step   <= mep_pkg::STEP_RST;
      cfg_r.y_step   <= mep_pkg::STEP_RST;
      max_iter_r     <= mep_pkg::MAX_ITER_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mep_pkg::CFG_X_ORIGIN: cfg_r.x_origin <= cfg_data;
        mep_pkg::CFG_Y_ORIGIN: cfg_r.y_origin <= cfg_data;
        mep_pkg::CFG_X_STEP:   cfg_r.x_step   <= cfg_data[mep_pkg::STEP_W-1:0];
        mep_pkg::CFG_Y_STEP:   cfg_r.y_step   <= cfg_data[mep_pkg::STEP_W-1:0];
        mep_pkg::CFG_MAX_ITER: max_iter_r     <= cfg_data[mep_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  mep_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  mep_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  mep_iter u_iter (
    .clk        (clk),
    .rst_n      (rst_n),
    .max_iter   (max_iter_r),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== rtl/mep_checker.sv =====
`timescale 1ns / 1ps

module mep_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [47:0]                     out_tdata
);

  // no result survives a reset cycle
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  // points that hit the limit are always dark grey
  a_inside_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |-> out_tdata[40:17] == mep_pkg::INSIDE_RGB)
    else $error("inside point not dark grey");

  // the gradient never holds the inside colour
  a_outside_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[16] |-> out_tdata[40:17] != mep_pkg::INSIDE_RGB)
    else $error("escaped point shows inside colour");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:41] == 7'd0)
    else $error("padding bits set in result beat");

endmodule

bind mandelbrot_escape_pixel_core mep_checker u_mep_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam logic [mep_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [mep_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [23:0] DARK_GREY = {8'd16, 8'd16, 8'd16};
  localparam logic [23:0] HUES [16] = '{
    {8'd66,  8'd30,  8'd15},  {8'd25,  8'd7,   8'd26},  {8'd9,   8'd1,   8'd47},
    {8'd4,   8'd4,   8'd73},  {8'd0,   8'd7,   8'd100}, {8'd12,  8'd44,  8'd138},
    {8'd24,  8'd82,  8'd177}, {8'd57,  8'd125, 8'd209}, {8'd134, 8'd181, 8'd229},
    {8'd211, 8'd236, 8'd248}, {8'd241, 8'd233, 8'd191}, {8'd248, 8'd201, 8'd95},
    {8'd255, 8'd170, 8'd0},   {8'd204, 8'd128, 8'd0},   {8'd153, 8'd87,  8'd0},
    {8'd106, 8'd52,  8'd3}
  };

  typedef struct packed {
    logic [15:0] count;
    logic        in_set;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pixel_result_t;

  class pixel_scoreboard;
    logic signed [31:0] x_org = mep_pkg::X_ORIGIN_RST;
    logic signed [31:0] y_org = mep_pkg::Y_ORIGIN_RST;
    logic [30:0] x_inc = mep_pkg::STEP_RST;
    logic [30:0] y_inc = mep_pkg::STEP_RST;
    logic [15:0] iter_limit = mep_pkg::MAX_ITER_RST;
    pixel_result_t expected_px[$];
    int errors = 0;

    function void set_reg(logic [mep_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        mep_pkg::CFG_X_ORIGIN: x_org = val;
        mep_pkg::CFG_Y_ORIGIN: y_org = val;
        mep_pkg::CFG_X_STEP:   x_inc = val[30:0];
        mep_pkg::CFG_Y_STEP:   y_inc = val[30:0];
        mep_pkg::CFG_MAX_ITER: iter_limit = val[15:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function pixel_result_t escape_pixel(logic [11:0] col, logic [11:0] row);
      longint cx, cy, acy, zx, zy, sx, sy, nx, ny;
      int unsigned n;
      pixel_result_t r;
      logic [23:0] rgb;
      cx = clamp32(longint'(x_org) + longint'(col) * longint'(x_inc));
      cy = clamp32(longint'(y_org) + longint'(row) * longint'(y_inc));
      acy = (cy < 0) ? -cy : cy;
      // imaginary part below half a step counts as the real axis
      if (2 * acy < longint'(y_inc)) cy = 0;
      zx = 0; zy = 0; sx = 0; sy = 0; n = 0;
      while (n < iter_limit && ($unsigned(sx) + $unsigned(sy)) < 64'h0400_0000_0000_0000) begin
        ny = clamp32(((zx * zy) >>> 27) + cy);
        nx = clamp32(((sx - sy) >>> 28) + cx);
        zx = nx;
        zy = ny;
        sx = zx * zx;
        sy = zy * zy;
        n++;
      end
      r.count = n[15:0];
      r.in_set = (n == iter_limit);
      rgb = r.in_set ? DARK_GREY : HUES[n[3:0]];
      {r.red, r.green, r.blue} = rgb;
      return r;
    endfunction

    function void note_pixel(logic [11:0] col, logic [11:0] row);
      expected_px.push_back(escape_pixel(col, row));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_pixel(logic [47:0] d);
      pixel_result_t want;
      if (expected_px.size() == 0) begin
        errors++;
        $display("%0t pixel result with none expected: actual %h", $time, d);
        return;
      end
      want = expected_px.pop_front();
      compare_field("iteration_count", want.count, d[15:0]);
      compare_field("inside_set", want.in_set, d[16]);
      compare_field("red", want.red, d[24:17]);
      compare_field("green", want.green, d[32:25]);
      compare_field("blue", want.blue, d[40:33]);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [23:0] in_tdata;   // pixel_column, pixel_row
  logic out_tvalid;
  logic out_tready;
  logic [47:0] out_tdata;  // iteration_count, inside_set, red, green, blue, zero pad
  logic cfg_valid;
  logic cfg_ready;
  logic [mep_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  pixel_scoreboard sb = new();
  bit calm = 0;
  bit hold_req = 0;

  mandelbrot_escape_pixel_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_pixel(in_tdata[11:0], in_tdata[23:12]);
    if (rst_n && out_tvalid && out_tready) sb.check_pixel(out_tdata);
  end

  function automatic bit take_gap();
    return !calm && ($urandom_range(0, 99) < 32);
  endfunction

  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
    while (take_gap()) begin
      in_tvalid = 0;
      @(negedge clk);
    end
    in_tvalid = 1;
    in_tdata = {row, col};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [mep_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic drain();
    in_tvalid = 0;
    while (sb.expected_px.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_view(input logic [31:0] xo, input logic [31:0] yo,
                          input logic [31:0] xs, input logic [31:0] ys,
                          input logic [31:0] lim);
    drain();
    write_reg(mep_pkg::CFG_X_ORIGIN, xo);
    write_reg(mep_pkg::CFG_Y_ORIGIN, yo);
    write_reg(mep_pkg::CFG_X_STEP, xs);
    write_reg(mep_pkg::CFG_Y_STEP, ys);
    write_reg(mep_pkg::CFG_MAX_ITER, lim);
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        out_tready = 0;
        hold_left--;
      end else begin
        out_tready = !take_gap();
      end
    end
  end

  initial begin
    logic [31:0] xo, yo, lim;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_valid = 0;
    cfg_index = mep_pkg::CFG_X_ORIGIN;
    cfg_data = '0;
    repeat (4) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // power-on view: corners, real axis points and alternating bits
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd2560, 12'd2048);
    send_pixel(12'd1536, 12'd2048);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);

    // zero and unit iteration limits
    drain();
    write_reg(mep_pkg::CFG_MAX_ITER, 32'd0);
    send_pixel(12'd100, 12'd100);
    send_pixel(12'd4095, 12'd0);
    drain();
    write_reg(mep_pkg::CFG_MAX_ITER, 32'd1);
    send_pixel(12'd2560, 12'd2048);
    send_pixel(12'd0, 12'd0);

    // c saturating at both ends of the range
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd16);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd0, 12'd0);

    // imaginary part just under and exactly at half a step
    set_view(32'hF000_0000, 32'hFFFE_0001, 32'd0, 32'h0004_0000, 32'd64);
    send_pixel(12'd7, 12'd0);
    send_pixel(12'd7, 12'd1);
    drain();
    write_reg(mep_pkg::CFG_Y_ORIGIN, 32'hFFFE_0000);
    send_pixel(12'd7, 12'd0);

    // writes to unused indexes must leave the registers alone
    drain();
    write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_HI, 32'h1234_5678);
    send_pixel(12'd3, 12'd0);

    // full iteration limit: origin stays bounded, c = -2 escapes on the boundary
    set_view(32'd0, 32'd0, 32'd0, 32'd0, 32'h0000_FFFF);
    send_pixel(12'd4095, 12'd4095);
    drain();
    write_reg(mep_pkg::CFG_X_ORIGIN, 32'hE000_0000);
    send_pixel(12'd0, 12'd0);

    for (int ph = 0; ph < 8; ph++) begin
      xo = $urandom_range(0, 32'h3000_0000) - 32'h2800_0000;
      yo = $urandom_range(0, 32'h2000_0000) - 32'h2000_0000;
      lim = (ph == 0) ? $urandom_range(1, 8) : $urandom_range(1, 128);
      if (ph == 2) begin
        // raw register values, upper bits of narrow registers included
        set_view($urandom, $urandom, $urandom, $urandom,
                 {16'($urandom_range(0, 16'hFFFF)), 16'(lim)});
      end else begin
        set_view(xo, yo, $urandom_range(0, 1 << 19), $urandom_range(0, 1 << 19), lim);
      end
      calm = (ph == 5);
      if (ph == 0) hold_req = 1;
      repeat (216) send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      calm = 0;
    end

    drain();
    repeat (40) @(negedge clk);
    if (sb.errors == 0 && sb.expected_px.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(40_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
